[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SGF splitter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SGFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, live during reset.
`define SGFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/sgfs_pkg.sv]
// ----------------------------------------------------------------------------
// sgfs_pkg
// Types and constants of the SGF game stream splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgfs_pkg;

  localparam int unsigned DEPTH_W = 10;
  localparam int unsigned CNT_W   = 16;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [7:0] data;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic             append;
    logic [7:0]       byte_out;
    logic             clear_buffer;
    logic             game_done;
    logic [CNT_W-1:0] game_total;
    logic             tag_error;
    logic [CNT_W-1:0] error_line;
  } res_t;

endpackage

[hw/rtl/sgfs_if.sv]
// ----------------------------------------------------------------------------
// sgfs channel interfaces
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sgfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       end_of_stream;

  modport source (output valid, output data, output end_of_stream, input ready);
  modport sink   (input valid, input data, input end_of_stream, output ready);
endinterface

interface sgfs_out_if;
  logic        valid;
  logic        ready;
  logic        append;
  logic [7:0]  byte_out;
  logic        clear_buffer;
  logic        game_done;
  logic [15:0] game_total;
  logic        tag_error;
  logic [15:0] error_line;

  modport source (output valid, output append, output byte_out, output clear_buffer,
                  output game_done, output game_total, output tag_error,
                  output error_line, input ready);
  modport sink   (input valid, input append, input byte_out, input clear_buffer,
                  input game_done, input game_total, input tag_error,
                  input error_line, output ready);
endinterface

interface sgfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/sgfs_in_stage.sv]
// ----------------------------------------------------------------------------
// sgfs_in_stage
// Input register; refills in the same cycle the held item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgfs_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  sgfs_in_if.sink          in_ch,
  input  logic             take,
  output sgfs_pkg::stage_t stg
);

  logic            vld_r;
  sgfs_pkg::item_t item_r;
  logic            acc;

  assign in_ch.ready = !vld_r || take;
  assign acc         = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (acc) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_r.data          <= in_ch.data;
      item_r.end_of_stream <= in_ch.end_of_stream;
    end
  end

  assign stg.vld  = vld_r;
  assign stg.item = item_r;

endmodule

[hw/rtl/sgfs_parse_core.sv]
// ----------------------------------------------------------------------------
// sgfs_parse_core
// Parser state, game limit register and per-byte decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgfs_parse_core #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  input  sgfs_pkg::stage_t stg,
  input  logic             take,
  output logic             res_vld,
  output sgfs_pkg::res_t   res
);

  localparam logic [sgfs_pkg::DEPTH_W-1:0] DEPTH_LIM = sgfs_pkg::DEPTH_W'(MAX_DEPTH);

  logic [sgfs_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic                         brk_r, brk_nxt;
  logic                         esc_r, esc_nxt;
  logic                         skip_r, skip_nxt;
  logic [sgfs_pkg::CNT_W-1:0]   line_r, line_nxt;
  logic [sgfs_pkg::CNT_W-1:0]   games_r, games_nxt;
  logic [15:0]                  max_r;

  logic [7:0] c;
  logic       eos;
  logic       stopped;
  logic       is_space;

  assign c        = stg.item.data;
  assign eos      = stg.item.end_of_stream;
  assign stopped  = games_r > max_r;
  assign is_space = (c == sgfs_pkg::CH_SPACE) ||
                    (c inside {[sgfs_pkg::CH_TAB:sgfs_pkg::CH_CR]});
  assign res_vld  = stg.vld && (eos || !stopped);

  always_comb begin
    depth_nxt = depth_r;
    brk_nxt   = brk_r;
    esc_nxt   = esc_r;
    skip_nxt  = skip_r;
    line_nxt  = line_r;
    games_nxt = games_r;
    res       = '0;
    if (eos) begin
      res.game_done  = (games_r == '0);
      res.game_total = (games_r == '0) ? sgfs_pkg::CNT_W'(1) : games_r;
      depth_nxt = '0;
      brk_nxt   = 1'b0;
      esc_nxt   = 1'b0;
      skip_nxt  = 1'b0;
      line_nxt  = '0;
      games_nxt = '0;
    end else if (!stopped) begin
      if (skip_r) begin
        if (!is_space) begin
          skip_nxt = 1'b0;
        end
      end else if (esc_r) begin
        esc_nxt    = 1'b0;
        res.append = 1'b1;
      end else begin
        res.append = 1'b1;
        if (c == sgfs_pkg::CH_NL && line_r != sgfs_pkg::CNT_MAX) begin
          line_nxt = line_r + 1'b1;
        end
        if (c == sgfs_pkg::CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (c == sgfs_pkg::CH_LPAREN && !brk_r) begin
          if (depth_r == '0) begin
            skip_nxt         = 1'b1;
            res.clear_buffer = 1'b1;
            res.append       = 1'b0;
          end
          if (depth_r < DEPTH_LIM) begin
            depth_nxt = depth_r + 1'b1;
          end
        end else if (c == sgfs_pkg::CH_RPAREN && !brk_r) begin
          if (depth_r != '0) begin
            depth_nxt = depth_r - 1'b1;
            if (depth_r == sgfs_pkg::DEPTH_W'(1)) begin
              res.game_done = 1'b1;
              if (games_r != sgfs_pkg::CNT_MAX) begin
                games_nxt = games_r + 1'b1;
              end
            end
          end
        end else if (c == sgfs_pkg::CH_LBRACK && !brk_r) begin
          brk_nxt = 1'b1;
        end else if (c == sgfs_pkg::CH_RBRACK) begin
          if (!brk_r) begin
            res.tag_error  = 1'b1;
            res.error_line = line_r;
          end
          brk_nxt = 1'b0;
        end
      end
      res.byte_out   = res.append ? c : 8'h00;
      res.game_total = games_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      brk_r   <= 1'b0;
      esc_r   <= 1'b0;
      skip_r  <= 1'b0;
      line_r  <= '0;
      games_r <= '0;
    end else if (take) begin
      depth_r <= depth_nxt;
      brk_r   <= brk_nxt;
      esc_r   <= esc_nxt;
      skip_r  <= skip_nxt;
      line_r  <= line_nxt;
      games_r <= games_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= 16'hFFFF;
    end else if (cfg_we) begin
      max_r <= cfg_data;
    end
  end

endmodule

[hw/rtl/sgfs_out_stage.sv]
// ----------------------------------------------------------------------------
// sgfs_out_stage
// Result register driving the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgfs_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_vld,
  input  sgfs_pkg::res_t res,
  output logic           can_take,
  sgfs_out_if.source     out_ch
);

  logic           vld_r;
  sgfs_pkg::res_t res_r;
  logic           load;

  assign can_take = !vld_r || out_ch.ready;
  assign load     = res_vld && can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.append       = res_r.append;
  assign out_ch.byte_out     = res_r.byte_out;
  assign out_ch.clear_buffer = res_r.clear_buffer;
  assign out_ch.game_done    = res_r.game_done;
  assign out_ch.game_total   = res_r.game_total;
  assign out_ch.tag_error    = res_r.tag_error;
  assign out_ch.error_line   = res_r.error_line;

endmodule

[hw/rtl/sgf_game_stream_splitter.sv]
// ----------------------------------------------------------------------------
// sgf_game_stream_splitter
// Splits a byte stream of game-record text into games, one byte per cycle.
//
//   channel | dir | payload
//   in_ch   | in  | data[7:0], end_of_stream
//   out_ch  | out | append, byte_out, clear_buffer, game_done, game_total,
//           |     | tag_error, error_line
//   cfg_ch  | in  | data[15:0] -> max_game_index, always ready
//
// One byte per cycle sustained while the output does not stall. Each byte
// is held in the input register, then decoded into the result register.
// Bytes ignored after the game limit produce no result.
// rst_n is synchronous; it clears parser state and sets max_game_index to
// 65535. An output stall holds the result and backs up through the input
// register once that register holds a byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgf_game_stream_splitter #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  sgfs_in_if.sink    in_ch,
  sgfs_out_if.source out_ch,
  sgfs_cfg_if.sink   cfg_ch
);

  sgfs_pkg::stage_t stg;
  sgfs_pkg::res_t   res;
  logic             res_vld;
  logic             can_take;
  logic             take;

  assign cfg_ch.ready = 1'b1;
  assign take         = stg.vld && can_take;

  sgfs_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stg   (stg)
  );

  sgfs_parse_core #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_ch.data),
    .stg      (stg),
    .take     (take),
    .res_vld  (res_vld),
    .res      (res)
  );

  sgfs_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_vld  (res_vld),
    .res      (res),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

endmodule

[hw/rtl/sgfs_checker.sv]
// ----------------------------------------------------------------------------
// sgfs_checker
// Port-level checks on the splitter result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        append,
  input logic [7:0]  byte_out,
  input logic        clear_buffer,
  input logic        game_done,
  input logic        tag_error,
  input logic [15:0] error_line
);

  `SGFS_ASSERT_NEXT(a_rst_idle, !rst_n, !out_valid, "result valid right after reset")
  `SGFS_ASSERT_NEXT(a_stall_hold, rst_n && out_valid && !out_ready, out_valid && $stable(byte_out) && $stable(error_line), "stalled result changed")
  `SGFS_ASSERT_IMP(a_clear_alone, out_valid && clear_buffer, !append && !game_done && !tag_error, "clear with other flags")
  `SGFS_ASSERT_IMP(a_byte_gated, out_valid && !append, byte_out == 8'h00, "byte_out set without append")
  `SGFS_ASSERT_IMP(a_line_gated, out_valid && !tag_error, error_line == 16'h0000, "error_line without tag error")

endmodule

bind sgf_game_stream_splitter sgfs_checker u_sgfs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .append       (out_ch.append),
  .byte_out     (out_ch.byte_out),
  .clear_buffer (out_ch.clear_buffer),
  .game_done    (out_ch.game_done),
  .tag_error    (out_ch.tag_error),
  .error_line   (out_ch.error_line)
);
